>>> hw/rtl/cpad_pkg.sv
// Shared types, constants and the sine table for the polar angle pipeline.
package cpad_pkg;

  localparam int SIN_W   = 34;   // table entries are below 2^34
  localparam int DEG_W   = 7;    // degree index within one quadrant
  localparam int ANGLE_W = 9;    // whole-turn angle in degrees
  localparam int STEPS   = 7;    // binary search steps over 0..89

  localparam logic [DEG_W-1:0]   MAX_DEG = 7'd89;
  localparam logic [DEG_W-1:0]   QUARTER = 7'd90;
  localparam logic [ANGLE_W-1:0] QUARTER_ANGLE = 9'd90;

  // Control that travels with each request through the pipeline.
  typedef struct packed {
    logic             zero;   // origin request, forces angle 0
    logic [1:0]       quad;   // whole quarter turns removed by the fold
    logic [DEG_W-1:0] deg;    // degrees found so far in the quadrant
  } meta_t;

  // sin(d) scaled by 10^10, rounded; indexes above 90 read zero.
  function automatic logic [SIN_W-1:0] sin_lut(input logic [DEG_W-1:0] idx);
    logic [SIN_W-1:0] v;
    unique case (idx)
      7'd0:  v = 34'd0;
      7'd1:  v = 34'd174524064;
      7'd2:  v = 34'd348994967;
      7'd3:  v = 34'd523359562;
      7'd4:  v = 34'd697564737;
      7'd5:  v = 34'd871557427;
      7'd6:  v = 34'd1045284633;
      7'd7:  v = 34'd1218693434;
      7'd8:  v = 34'd1391731010;
      7'd9:  v = 34'd1564344650;
      7'd10: v = 34'd1736481777;
      7'd11: v = 34'd1908089954;
      7'd12: v = 34'd2079116908;
      7'd13: v = 34'd2249510543;
      7'd14: v = 34'd2419218956;
      7'd15: v = 34'd2588190451;
      7'd16: v = 34'd2756373558;
      7'd17: v = 34'd2923717047;
      7'd18: v = 34'd3090169944;
      7'd19: v = 34'd3255681545;
      7'd20: v = 34'd3420201433;
      7'd21: v = 34'd3583679495;
      7'd22: v = 34'd3746065934;
      7'd23: v = 34'd3907311285;
      7'd24: v = 34'd4067366431;
      7'd25: v = 34'd4226182617;
      7'd26: v = 34'd4383711468;
      7'd27: v = 34'd4539904997;
      7'd28: v = 34'd4694715628;
      7'd29: v = 34'd4848096202;
      7'd30: v = 34'd5000000000;
      7'd31: v = 34'd5150380749;
      7'd32: v = 34'd5299192642;
      7'd33: v = 34'd5446390350;
      7'd34: v = 34'd5591929035;
      7'd35: v = 34'd5735764364;
      7'd36: v = 34'd5877852523;
      7'd37: v = 34'd6018150232;
      7'd38: v = 34'd6156614753;
      7'd39: v = 34'd6293203910;
      7'd40: v = 34'd6427876097;
      7'd41: v = 34'd6560590290;
      7'd42: v = 34'd6691306064;
      7'd43: v = 34'd6819983601;
      7'd44: v = 34'd6946583705;
      7'd45: v = 34'd7071067812;
      7'd46: v = 34'd7193398003;
      7'd47: v = 34'd7313537016;
      7'd48: v = 34'd7431448255;
      7'd49: v = 34'd7547095802;
      7'd50: v = 34'd7660444431;
      7'd51: v = 34'd7771459615;
      7'd52: v = 34'd7880107536;
      7'd53: v = 34'd7986355100;
      7'd54: v = 34'd8090169944;
      7'd55: v = 34'd8191520443;
      7'd56: v = 34'd8290375726;
      7'd57: v = 34'd8386705679;
      7'd58: v = 34'd8480480962;
      7'd59: v = 34'd8571673007;
      7'd60: v = 34'd8660254038;
      7'd61: v = 34'd8746197071;
      7'd62: v = 34'd8829475929;
      7'd63: v = 34'd8910065242;
      7'd64: v = 34'd8987940463;
      7'd65: v = 34'd9063077870;
      7'd66: v = 34'd9135454576;
      7'd67: v = 34'd9205048535;
      7'd68: v = 34'd9271838546;
      7'd69: v = 34'd9335804265;
      7'd70: v = 34'd9396926208;
      7'd71: v = 34'd9455185756;
      7'd72: v = 34'd9510565163;
      7'd73: v = 34'd9563047560;
      7'd74: v = 34'd9612616959;
      7'd75: v = 34'd9659258263;
      7'd76: v = 34'd9702957263;
      7'd77: v = 34'd9743700648;
      7'd78: v = 34'd9781476007;
      7'd79: v = 34'd9816271834;
      7'd80: v = 34'd9848077530;
      7'd81: v = 34'd9876883406;
      7'd82: v = 34'd9902680687;
      7'd83: v = 34'd9925461516;
      7'd84: v = 34'd9945218954;
      7'd85: v = 34'd9961946981;
      7'd86: v = 34'd9975640503;
      7'd87: v = 34'd9986295348;
      7'd88: v = 34'd9993908270;
      7'd89: v = 34'd9998476952;
      7'd90: v = 34'd10000000000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/cpad_fold.sv
// Input stage: fold the point into the first quadrant and note the quarter turns.
module cpad_fold import cpad_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic                          valid,
  input  logic                          ready,
  output meta_t                         meta,
  output logic        [COORD_WIDTH-1:0] mag_a,
  output logic        [COORD_WIDTH-1:0] mag_b
);

  logic             x_zero, y_zero, x_neg, y_neg;
  logic [COORD_WIDTH-1:0] x_abs, y_abs;
  meta_t            meta_next;
  logic [COORD_WIDTH-1:0] a_next, b_next;

  assign in_ready = !valid || ready;

  always_comb begin
    x_zero = (x_coord == '0);
    y_zero = (y_coord == '0);
    x_neg  = x_coord[COORD_WIDTH-1];
    y_neg  = y_coord[COORD_WIDTH-1];
    // Negation of the most negative value still reads right as unsigned.
    x_abs  = COORD_WIDTH'('0) - COORD_WIDTH'(x_coord);
    y_abs  = COORD_WIDTH'('0) - COORD_WIDTH'(y_coord);
    meta_next.zero = x_zero && y_zero;
    meta_next.deg  = '0;
    priority if (!x_neg && !x_zero && !y_neg) begin
      meta_next.quad = 2'd0;
      a_next = COORD_WIDTH'(x_coord);
      b_next = COORD_WIDTH'(y_coord);
    end else if ((x_neg || x_zero) && !y_neg && !y_zero) begin
      meta_next.quad = 2'd1;
      a_next = COORD_WIDTH'(y_coord);
      b_next = x_abs;
    end else if (x_neg && (y_neg || y_zero)) begin
      meta_next.quad = 2'd2;
      a_next = x_abs;
      b_next = y_abs;
    end else begin
      meta_next.quad = 2'd3;
      a_next = y_abs;
      b_next = COORD_WIDTH'(x_coord);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      meta  <= meta_next;
      mag_a <= a_next;
      mag_b <= b_next;
    end
  end

endmodule

>>> hw/rtl/cpad_step.sv
// One binary search step: test one degree bit with exact products, then compare.
module cpad_step import cpad_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int BIT_POS     = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  meta_t                  in_meta,
  input  logic [COORD_WIDTH-1:0] in_a,
  input  logic [COORD_WIDTH-1:0] in_b,
  output logic                   valid,
  input  logic                   ready,
  output meta_t                  meta,
  output logic [COORD_WIDTH-1:0] mag_a,
  output logic [COORD_WIDTH-1:0] mag_b
);

  localparam int PROD_W = COORD_WIDTH + SIN_W;
  localparam logic [DEG_W-1:0] STEP_BIT = DEG_W'(1) << BIT_POS;

  // Product stage
  logic                   m_valid, m_ready;
  meta_t                  m_meta;
  logic [COORD_WIDTH-1:0] m_a, m_b;
  logic [DEG_W-1:0]       m_cand;
  logic                   m_ok;
  logic [PROD_W-1:0]      m_pb, m_pa;

  logic [DEG_W-1:0]       cand, cos_idx;
  logic                   cand_ok;
  logic [PROD_W-1:0]      pb_next, pa_next;

  // Compare stage
  logic                   pass;
  meta_t                  meta_next;

  assign m_ready  = !valid || ready;
  assign in_ready = !m_valid || m_ready;

  always_comb begin
    cand    = in_meta.deg | STEP_BIT;
    cand_ok = (cand <= MAX_DEG);
    cos_idx = cand_ok ? (QUARTER - cand) : '0;
    pb_next = PROD_W'(in_b) * PROD_W'(sin_lut(cos_idx));
    pa_next = PROD_W'(in_a) * PROD_W'(sin_lut(cand));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (in_ready) begin
      m_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_meta <= in_meta;
      m_a    <= in_a;
      m_b    <= in_b;
      m_cand <= cand;
      m_ok   <= cand_ok;
      m_pb   <= pb_next;
      m_pa   <= pa_next;
    end
  end

  // Keep the candidate when it is at most 89 and b*cos(d) >= a*sin(d).
  always_comb begin
    pass      = m_ok && (m_pb >= m_pa);
    meta_next = m_meta;
    if (pass) begin
      meta_next.deg = m_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (m_ready) begin
      valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && m_valid) begin
      meta  <= meta_next;
      mag_a <= m_a;
      mag_b <= m_b;
    end
  end

endmodule

>>> hw/rtl/cpad_out.sv
// Output register: merge quarter turns and degrees into the full angle.
module cpad_out import cpad_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  meta_t              in_meta,
  output logic               valid,
  input  logic               stall,
  output logic [ANGLE_W-1:0] angle
);

  logic [ANGLE_W-1:0] angle_next;

  assign in_ready = !valid || !stall;

  always_comb begin
    if (in_meta.zero) begin
      angle_next = '0;
    end else begin
      angle_next = ANGLE_W'(in_meta.quad) * QUARTER_ANGLE + ANGLE_W'(in_meta.deg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      angle <= angle_next;
    end
  end

endmodule

>>> hw/rtl/cartesian_to_polar_angle_degrees.sv
// Top level: pipelined polar angle, in whole degrees, of a signed Cartesian point.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   point    | point_valid / point_stall | x_coord, y_coord (signed)
//   angle    | angle_valid / angle_stall | angle_degrees (0..359)
//
// One request enters per cycle while angle_stall is low; the stages are one fold
// stage, seven search steps of two (product, compare), and the output register.
// The per-cycle figure is set by the two table-by-magnitude multipliers in each
// search step, which are registered before their compare.
// Reset (rst, synchronous) clears only the valid bits; payload holds no reset.
// Each stage advances when its successor is empty or advancing, so a held
// angle_stall fills bubbles first and then stalls the point channel.
module cartesian_to_polar_angle_degrees import cpad_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          point_valid,
  output logic                          point_stall,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic                          angle_valid,
  input  logic                          angle_stall,
  output logic        [ANGLE_W-1:0]     angle_degrees
);

  // Stage k of the chain feeds search step k; index STEPS feeds the output.
  logic                   sv    [STEPS+1];
  logic                   sr    [STEPS+1];
  meta_t                  smeta [STEPS+1];
  logic [COORD_WIDTH-1:0] sa    [STEPS];
  logic [COORD_WIDTH-1:0] sb    [STEPS];
  logic                   fold_ready;

  assign point_stall = !fold_ready;

  // Fold the point into the quadrant x > 0, y >= 0.
  cpad_fold #(.COORD_WIDTH(COORD_WIDTH)) u_fold (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point_valid),
    .in_ready (fold_ready),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .valid    (sv[0]),
    .ready    (sr[0]),
    .meta     (smeta[0]),
    .mag_a    (sa[0]),
    .mag_b    (sb[0])
  );

  // Binary search from the top degree bit down; the last step drops magnitudes.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k < STEPS - 1) begin : g_mid
      cpad_step #(.COORD_WIDTH(COORD_WIDTH), .BIT_POS(STEPS - 1 - k)) u_step (
        .clk      (clk),
        .rst      (rst),
        .in_valid (sv[k]),
        .in_ready (sr[k]),
        .in_meta  (smeta[k]),
        .in_a     (sa[k]),
        .in_b     (sb[k]),
        .valid    (sv[k+1]),
        .ready    (sr[k+1]),
        .meta     (smeta[k+1]),
        .mag_a    (sa[k+1]),
        .mag_b    (sb[k+1])
      );
    end else begin : g_last
      cpad_step #(.COORD_WIDTH(COORD_WIDTH), .BIT_POS(STEPS - 1 - k)) u_step (
        .clk      (clk),
        .rst      (rst),
        .in_valid (sv[k]),
        .in_ready (sr[k]),
        .in_meta  (smeta[k]),
        .in_a     (sa[k]),
        .in_b     (sb[k]),
        .valid    (sv[k+1]),
        .ready    (sr[k+1]),
        .meta     (smeta[k+1]),
        .mag_a    (),
        .mag_b    ()
      );
    end
  end

  // Hold the finished angle until the consumer takes it.
  cpad_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sv[STEPS]),
    .in_ready (sr[STEPS]),
    .in_meta  (smeta[STEPS]),
    .valid    (angle_valid),
    .stall    (angle_stall),
    .angle    (angle_degrees)
  );

endmodule

>>> verif/cartesian_to_polar_angle_degrees_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined Cartesian-to-polar angle block.
module cartesian_to_polar_angle_degrees_test;

  localparam int COORD_W      = 16;
  localparam int ANGLE_W      = cpad_pkg::ANGLE_W;
  localparam int RANDOM_ITEMS = 400;     // per idle/stall mix
  localparam int HOLD_CYCLES  = 80;      // long output hold, well past pipeline depth
  localparam int DRAIN_CYCLES = 40;      // pipeline is 16 deep
  localparam int REPORT_MAX   = 10;
  localparam int QUARTER_DEG  = 90;
  localparam int DIR_ROWS     = 24;

  localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] C_ONE = 16'sd1;
  localparam logic signed [COORD_W-1:0] C_NEG = -16'sd1;
  localparam logic signed [COORD_W-1:0] C_ZRO = 16'sd0;

  // Idle/stall mixes the random part walks through.
  typedef enum int {
    MIX_STEADY,
    MIX_SENDER_IDLE,
    MIX_RECEIVER_STALL,
    MIX_BOTH
  } mix_e;

  // One directed row; fixed marks rows whose angle is typed in here.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      fixed;
    logic [ANGLE_W-1:0]        angle;
  } point_row_t;

  // One angle the block still owes, with the point it came from.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ANGLE_W-1:0]        angle;
  } angle_due_t;

  // sin(d) scaled by 10^10, rounded, d = 0..90.
  longint unsigned sine_e10 [0:90] = '{
    64'd0, 64'd174524064, 64'd348994967, 64'd523359562, 64'd697564737,
    64'd871557427, 64'd1045284633, 64'd1218693434, 64'd1391731010, 64'd1564344650,
    64'd1736481777, 64'd1908089954, 64'd2079116908, 64'd2249510543, 64'd2419218956,
    64'd2588190451, 64'd2756373558, 64'd2923717047, 64'd3090169944, 64'd3255681545,
    64'd3420201433, 64'd3583679495, 64'd3746065934, 64'd3907311285, 64'd4067366431,
    64'd4226182617, 64'd4383711468, 64'd4539904997, 64'd4694715628, 64'd4848096202,
    64'd5000000000, 64'd5150380749, 64'd5299192642, 64'd5446390350, 64'd5591929035,
    64'd5735764364, 64'd5877852523, 64'd6018150232, 64'd6156614753, 64'd6293203910,
    64'd6427876097, 64'd6560590290, 64'd6691306064, 64'd6819983601, 64'd6946583705,
    64'd7071067812, 64'd7193398003, 64'd7313537016, 64'd7431448255, 64'd7547095802,
    64'd7660444431, 64'd7771459615, 64'd7880107536, 64'd7986355100, 64'd8090169944,
    64'd8191520443, 64'd8290375726, 64'd8386705679, 64'd8480480962, 64'd8571673007,
    64'd8660254038, 64'd8746197071, 64'd8829475929, 64'd8910065242, 64'd8987940463,
    64'd9063077870, 64'd9135454576, 64'd9205048535, 64'd9271838546, 64'd9335804265,
    64'd9396926208, 64'd9455185756, 64'd9510565163, 64'd9563047560, 64'd9612616959,
    64'd9659258263, 64'd9702957263, 64'd9743700648, 64'd9781476007, 64'd9816271834,
    64'd9848077530, 64'd9876883406, 64'd9902680687, 64'd9925461516, 64'd9945218954,
    64'd9961946981, 64'd9975640503, 64'd9986295348, 64'd9993908270, 64'd9998476952,
    64'd10000000000
  };

  // Directed rows: origin, axes, diagonals, extremes, and the point just
  // below the positive x axis that must stay at 359.
  point_row_t directed_rows [DIR_ROWS] = '{
    '{C_ZRO, C_ZRO, 1'b1, 9'd0},
    '{C_ONE, C_ZRO, 1'b1, 9'd0},
    '{C_ZRO, C_ONE, 1'b1, 9'd90},
    '{C_NEG, C_ZRO, 1'b1, 9'd180},
    '{C_ZRO, C_NEG, 1'b1, 9'd270},
    '{C_ONE, C_ONE, 1'b1, 9'd45},
    '{C_NEG, C_ONE, 1'b1, 9'd135},
    '{C_NEG, C_NEG, 1'b1, 9'd225},
    '{C_ONE, C_NEG, 1'b1, 9'd315},
    '{C_MAX, C_ZRO, 1'b1, 9'd0},
    '{C_ZRO, C_MAX, 1'b1, 9'd90},
    '{C_MIN, C_ZRO, 1'b1, 9'd180},
    '{C_ZRO, C_MIN, 1'b1, 9'd270},
    '{C_MAX, C_MAX, 1'b1, 9'd45},
    '{C_MIN, C_MIN, 1'b1, 9'd225},
    '{C_MAX, C_NEG, 1'b1, 9'd359},
    '{C_MIN, C_NEG, 1'b1, 9'd180},
    '{C_NEG, C_MAX, 1'b1, 9'd90},
    '{C_MIN, C_MAX, 1'b0, 9'd0},
    '{C_MAX, C_MIN, 1'b0, 9'd0},
    '{C_MIN, C_ONE, 1'b0, 9'd0},
    '{16'sd3, 16'sd4, 1'b0, 9'd0},
    '{16'sd4, 16'sd3, 1'b0, 9'd0},
    '{C_MAX, C_ONE, 1'b0, 9'd0}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      point_valid = 1'b0;
  logic                      point_stall;
  logic signed [COORD_W-1:0] x_coord = '0;
  logic signed [COORD_W-1:0] y_coord = '0;
  logic                      angle_valid;
  logic                      angle_stall = 1'b0;
  logic [ANGLE_W-1:0]        angle_degrees;

  angle_due_t angles_due [$];

  // Owned by the stimulus process.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned points_sent = 0;

  // Owned by the stall process.
  int unsigned holds_started = 0;
  int unsigned hold_left = 0;

  // Owned by the result monitor.
  int unsigned angles_checked = 0;
  int unsigned mismatches = 0;
  int unsigned input_stall_cycles = 0;

  cartesian_to_polar_angle_degrees #(
    .COORD_WIDTH (COORD_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .point_valid   (point_valid),
    .point_stall   (point_stall),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .angle_valid   (angle_valid),
    .angle_stall   (angle_stall),
    .angle_degrees (angle_degrees)
  );

  always #2 clk = ~clk;

  // Expected angle: fold into the first quadrant by whole quarter turns,
  // then take the largest degree d with b*cos(d) >= a*sin(d), exactly.
  function automatic logic [ANGLE_W-1:0] polar_angle_deg(
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] py
  );
    longint          sx;
    longint          sy;
    longint unsigned mag_a;
    longint unsigned mag_b;
    int              quad;
    int              deg;
    sx = px;
    sy = py;
    if (sx == 0 && sy == 0)
      return '0;
    if (sx > 0 && sy >= 0) begin
      quad = 0; mag_a = sx;  mag_b = sy;
    end else if (sx <= 0 && sy > 0) begin
      quad = 1; mag_a = sy;  mag_b = -sx;
    end else if (sx < 0 && sy <= 0) begin
      quad = 2; mag_a = -sx; mag_b = -sy;
    end else begin
      quad = 3; mag_a = -sy; mag_b = sx;
    end
    deg = 0;
    while (deg < QUARTER_DEG - 1 &&
           mag_b * sine_e10[QUARTER_DEG - 1 - deg] >= mag_a * sine_e10[deg + 1])
      deg++;
    return ANGLE_W'(quad * QUARTER_DEG + deg);
  endfunction

  // Coordinates at or next to the ends of the range, and around zero.
  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MIN + C_ONE;
      2:       return C_NEG;
      3:       return C_ZRO;
      4:       return C_ONE;
      default: return C_MAX;
    endcase
  endfunction

  // Draw a point: half uniform, the rest small magnitudes, extremes, points
  // hugging an axis and points hugging a diagonal.
  task automatic pick_point(output logic signed [COORD_W-1:0] px,
                            output logic signed [COORD_W-1:0] py);
    int unsigned               kind;
    logic signed [COORD_W-1:0] off;
    logic signed [COORD_W-1:0] tmp;
    kind = $urandom_range(0, 9);
    case (kind)
      5, 6: begin
        px = COORD_W'(int'($urandom_range(0, 16)) - 8);
        py = COORD_W'(int'($urandom_range(0, 16)) - 8);
      end
      7: begin
        px = extreme_coord();
        py = extreme_coord();
      end
      8: begin
        px = COORD_W'($urandom);
        py = COORD_W'(int'($urandom_range(0, 4)) - 2);
        if ($urandom_range(0, 1) == 1) begin
          tmp = px; px = py; py = tmp;
        end
      end
      9: begin
        px  = COORD_W'($urandom);
        off = COORD_W'(int'($urandom_range(0, 4)) - 2);
        py  = (($urandom_range(0, 1) == 1) ? px : -px) + off;
      end
      default: begin
        px = COORD_W'($urandom);
        py = COORD_W'($urandom);
      end
    endcase
  endtask

  // Offer one request and hold it until the block takes it; queue the
  // angle it owes at the accepting edge.
  task automatic offer_point(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic [ANGLE_W-1:0]        owed);
    angle_due_t due;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      point_valid <= 1'b0;
      @(negedge clk);
    end
    point_valid <= 1'b1;
    x_coord     <= px;
    y_coord     <= py;
    do @(posedge clk); while (point_stall !== 1'b0);
    due.x     = px;
    due.y     = py;
    due.angle = owed;
    angles_due.push_back(due);
    points_sent++;
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Output stall: a long hold when one is asked for, else random stalls
  // at the current mix's rate.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      angle_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_started != holds_asked) begin
      angle_stall   <= 1'b1;
      hold_left     <= HOLD_CYCLES - 1;
      holds_started <= holds_started + 1;
    end else begin
      angle_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result monitor: compare each accepted angle with the oldest one owed.
  always @(posedge clk) begin
    angle_due_t due;
    if (!rst) begin
      if (point_valid && point_stall)
        input_stall_cycles++;
      if (angle_valid && !angle_stall) begin
        angles_checked++;
        if (angles_due.size() == 0) begin
          note_mismatch($sformatf("angle %0d with no request pending", angle_degrees));
        end else begin
          due = angles_due.pop_front();
          if (angle_degrees !== due.angle)
            note_mismatch($sformatf("point (%0d, %0d): expected %0d, got %0d",
                                    due.x, due.y, due.angle, angle_degrees));
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then four mixes of random points.
  initial begin
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    mix_e                      mix;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table with light idling on both sides.
    idle_pct  = 36;
    stall_pct = 36;
    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_point(directed_rows[r].x, directed_rows[r].y,
                  directed_rows[r].fixed ? directed_rows[r].angle
                                         : polar_angle_deg(directed_rows[r].x,
                                                           directed_rows[r].y));
    end

    for (int m = 0; m < 4; m++) begin
      mix = mix_e'(m);
      case (mix)
        MIX_STEADY:         begin idle_pct = 0;  stall_pct = 0;  end
        MIX_SENDER_IDLE:    begin idle_pct = 65; stall_pct = 0;  end
        MIX_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 65; end
        default:            begin idle_pct = 36; stall_pct = 36; end
      endcase
      // Hold the output long while points keep coming, so the pipeline
      // fills and stalls the point channel.
      if (mix == MIX_STEADY || mix == MIX_RECEIVER_STALL)
        holds_asked++;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        pick_point(px, py);
        offer_point(px, py, polar_angle_deg(px, py));
      end
    end

    @(negedge clk);
    point_valid <= 1'b0;

    // Drain: wait for every owed angle, then keep watching the output
    // to catch anything extra.
    while (angles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d points (directed corners/axes, then four idle/stall mixes).",
             points_sent);
    $display("Checked %0d angles, %0d input-stall cycles seen, %0d mismatches.",
             angles_checked, input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("PASS cartesian_to_polar_angle_degrees");
    end else begin
      $display("FAIL cartesian_to_polar_angle_degrees");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d angles still owed.", angles_due.size());
    $display("FAIL cartesian_to_polar_angle_degrees");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cpad_pkg.sv
hw/rtl/cpad_fold.sv
hw/rtl/cpad_step.sv
hw/rtl/cpad_out.sv
hw/rtl/cartesian_to_polar_angle_degrees.sv
verif/cartesian_to_polar_angle_degrees_test.sv
